// File: sv/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
// No dependencies; the interfaces, front end, back end and top level import this package.
package sem_pkg;

	localparam int DATA_W    = 8;     // gray, color and result width
	localparam int CFG_W     = 9;     // widest configuration register
	localparam int CFG_IDX_W = 1;     // configuration register index width
	localparam int SUM_W     = 10;    // width of a weighted 1,2,1 sum

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 1'd1;

	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_LINES = 256;
	localparam int CFG_RESET     = 256;   // reset value of both size registers
	localparam int MIN_SIZE      = 3;     // smallest usable row length or row count
	localparam int FIFO_DEPTH    = 4;

	// floor(s / 3) == (s * 683) >> 11 for every s below 2048
	localparam int GRAY_RECIP = 683;
	localparam int GRAY_SHIFT = 11;

	localparam int SAT_MAX = 255;

	// Per-pixel control flags handed from the front end to the back end.
	typedef struct packed {
		logic stored;    // line store entry at this column has been written before
		logic produce;   // pixel is interior and yields a result
		logic last;      // final interior pixel of the frame
	} sem_flags_t;

endpackage

// File: sv/sem_if.sv
// Handshake channels of the Sobel edge magnitude core: pixel input and result output.
// Depends on sem_pkg for the payload widths.
interface sem_pix_if import sem_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] red;
	logic [DATA_W-1:0] green;
	logic [DATA_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] edge_res;
	logic              last;

	modport source (output valid, output edge_res, output last, input ready);
	modport sink   (input valid, input edge_res, input last, output ready);
endinterface

// File: sv/sem_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for both line stores.
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/sem_fifo.sv
// Short register FIFO that decouples the pixel front end from the filter back end.
// Depends on nothing; the entry is an opaque vector.
module sem_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/sem_front.sv
// Front end: size registers, pixel acceptance, gray conversion and raster position tracking.
// Depends on sem_pkg and the pixel channel interface.
module sem_front import sem_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_LINES = DEF_MAX_LINES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	sem_pix_if.sink                      pix,
	input  logic                         fifo_full,
	output logic                         push,
	output logic [$clog2(MAX_WIDTH)-1:0] addr,
	output logic [DATA_W-1:0]            gray,
	output sem_flags_t                   flags
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_LINES);
	localparam int WLAST_RST = ((CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET) - 1;
	localparam int HLAST_RST = ((CFG_RESET > MAX_LINES) ? MAX_LINES : CFG_RESET) - 1;
	localparam int PROD_W = SUM_W + GRAY_SHIFT;

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     wlast_q;
	logic [RW-1:0]     hlast_q;
	logic [CW:0]       fill_q;
	logic [31:0]       cfg_ext;
	logic [31:0]       wlast_full;
	logic [31:0]       hlast_full;
	logic [SUM_W-1:0]  rgb_sum;
	logic [PROD_W-1:0] gray_prod;
	logic              end_col;
	logic              end_row;

	assign pix.ready = !fifo_full;
	assign push      = pix.valid && !fifo_full;

	// Size registers hold the clamped index of the last column and last row.
	always_comb begin
		cfg_ext = 32'(cfg_data);
		if (cfg_ext < 32'(MIN_SIZE)) begin
			wlast_full = 32'(MIN_SIZE - 1);
		end else if (cfg_ext > 32'(MAX_WIDTH)) begin
			wlast_full = 32'(MAX_WIDTH - 1);
		end else begin
			wlast_full = cfg_ext - 32'd1;
		end
		if (cfg_ext < 32'(MIN_SIZE)) begin
			hlast_full = 32'(MIN_SIZE - 1);
		end else if (cfg_ext > 32'(MAX_LINES)) begin
			hlast_full = 32'(MAX_LINES - 1);
		end else begin
			hlast_full = cfg_ext - 32'd1;
		end
	end

	assign rgb_sum   = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
	assign gray_prod = PROD_W'(rgb_sum) * PROD_W'(GRAY_RECIP);
	assign gray      = gray_prod[GRAY_SHIFT +: DATA_W];

	assign end_col = (col_q >= wlast_q);
	assign end_row = (row_q >= hlast_q);

	assign addr          = col_q;
	assign flags.stored  = ({1'b0, col_q} < fill_q);
	assign flags.produce = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign flags.last    = end_col && end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			fill_q  <= '0;
			wlast_q <= CW'(WLAST_RST);
			hlast_q <= RW'(HLAST_RST);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LINE_WIDTH: wlast_q <= wlast_full[CW-1:0];
					CFG_LINE_COUNT: hlast_q <= hlast_full[RW-1:0];
					default: ;
				endcase
			end
			if (push) begin
				// Columns are always visited upward from zero, so the written
				// entries of the line stores form one range starting at zero.
				if ({1'b0, col_q} >= fill_q) begin
					fill_q <= {1'b0, col_q} + 1'b1;
				end
				if (end_col) begin
					col_q <= '0;
					row_q <= end_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: sv/sem_back.sv
// Back end: line stores, 3x3 window, Sobel sums, magnitude and output register.
// Depends on sem_pkg, sem_ram and the result channel interface.
module sem_back import sem_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fifo_empty,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  logic [DATA_W-1:0]            gray,
	input  sem_flags_t                   flags,
	output logic                         pop,
	sem_res_if.source                    res
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                adv;
	logic                valid_s1;
	logic [CW-1:0]       addr_s1;
	logic [DATA_W-1:0]   gray_s1;
	sem_flags_t          flags_s1;
	logic [DATA_W-1:0]   upper_rd;
	logic [DATA_W-1:0]   lower_rd;
	logic [DATA_W-1:0]   top;
	logic [DATA_W-1:0]   mid;
	logic                wr_en;

	logic                valid_s2;
	logic                produce_s2;
	logic                last_s2;
	logic [DATA_W-1:0]   win_s2 [9];

	logic                valid_s3;
	logic                last_s3;
	logic [SUM_W-1:0]    tsum_s3;
	logic [SUM_W-1:0]    bsum_s3;
	logic [SUM_W-1:0]    lsum_s3;
	logic [SUM_W-1:0]    rsum_s3;

	logic                valid_s4;
	logic                last_s4;
	logic [SUM_W-1:0]    dx_s4;
	logic [SUM_W-1:0]    dy_s4;
	logic [SUM_W-1:0]    dx;
	logic [SUM_W-1:0]    dy;
	logic [SUM_W:0]      mag;

	logic                out_valid_q;
	logic [DATA_W-1:0]   edge_q;
	logic                last_q;

	// The whole back end moves in lockstep whenever the output slot can take a value.
	assign adv   = !out_valid_q || res.ready;
	assign pop   = adv && !fifo_empty;
	assign wr_en = adv && valid_s1;

	// Entries never written since reset read as zero.
	assign top = flags_s1.stored ? upper_rd : '0;
	assign mid = flags_s1.stored ? lower_rd : '0;

	sem_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (mid),
		.re    (adv),
		.raddr (addr),
		.rdata (upper_rd)
	);

	sem_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (gray_s1),
		.re    (adv),
		.raddr (addr),
		.rdata (lower_rd)
	);

	always_comb begin
		dx  = (tsum_s3 >= bsum_s3) ? tsum_s3 - bsum_s3 : bsum_s3 - tsum_s3;
		dy  = (rsum_s3 >= lsum_s3) ? rsum_s3 - lsum_s3 : lsum_s3 - rsum_s3;
		mag = {1'b0, dx_s4} + {1'b0, dy_s4};
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= addr;
			gray_s1  <= gray;
			flags_s1 <= flags;
			if (valid_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_s2[k*3 + 0] <= win_s2[k*3 + 1];
					win_s2[k*3 + 1] <= win_s2[k*3 + 2];
				end
				win_s2[2] <= top;
				win_s2[5] <= mid;
				win_s2[8] <= gray_s1;
			end
			produce_s2 <= flags_s1.produce;
			last_s2    <= flags_s1.last;
			tsum_s3 <= SUM_W'(win_s2[0]) + SUM_W'({win_s2[1], 1'b0}) + SUM_W'(win_s2[2]);
			bsum_s3 <= SUM_W'(win_s2[6]) + SUM_W'({win_s2[7], 1'b0}) + SUM_W'(win_s2[8]);
			lsum_s3 <= SUM_W'(win_s2[0]) + SUM_W'({win_s2[3], 1'b0}) + SUM_W'(win_s2[6]);
			rsum_s3 <= SUM_W'(win_s2[2]) + SUM_W'({win_s2[5], 1'b0}) + SUM_W'(win_s2[8]);
			last_s3 <= last_s2;
			dx_s4   <= dx;
			dy_s4   <= dy;
			last_s4 <= last_s3;
			edge_q  <= (mag > (SUM_W + 1)'(SAT_MAX)) ? DATA_W'(SAT_MAX) : mag[DATA_W-1:0];
			last_q  <= last_s4;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !fifo_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && produce_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.edge_res = edge_q;
	assign res.last     = last_q;

endmodule

// File: sv/sobel_edge_magnitude_core.sv
// Sobel edge magnitude core. RGB pixels enter in raster order on the pix channel and are
// turned to gray as the integer mean of red, green and blue. Two line stores and a 3x3
// window give, for every pixel at row 2 or later and column 2 or later, the value
// min(255, |gx| + |gy|) of the pixel one row up and one column left; gx is the top window
// row minus the bottom row and gy the right column minus the left, both weighted 1,2,1.
// Pixels in the first two rows or columns give no result, and last marks the result of
// the final pixel of the frame. line_width and line_count (register indexes 0 and 1,
// clamped to 3..MAX_WIDTH and 3..MAX_LINES) set the frame size; write them only while the
// block is idle. The core takes one pixel per clock while its queue has room and sustains
// one pixel per clock while results are taken: each line store is a RAM with one read and
// one write per cycle, and every pixel uses exactly one of each. Results pass the read,
// window, sum and difference stages and the output register. A four-entry queue separates
// the pixel front end from the filter pipeline, so a stalled result consumer holds the
// filter while pixels keep entering until the queue fills. No clearing pass is needed after
// reset: a fill count makes line store entries that were never written read as zero.
module sobel_edge_magnitude_core import sem_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_LINES = DEF_MAX_LINES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sem_pix_if.sink              pix,
	sem_res_if.source            res
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = CW + DATA_W + $bits(sem_flags_t);

	logic              push;
	logic              fifo_full;
	logic              fifo_empty;
	logic              pop;
	logic [CW-1:0]     f_addr;
	logic [DATA_W-1:0] f_gray;
	sem_flags_t        f_flags;
	logic [CW-1:0]     b_addr;
	logic [DATA_W-1:0] b_gray;
	sem_flags_t        b_flags;
	logic [EW-1:0]     push_data;
	logic [EW-1:0]     pop_data;

	// Front end: registers, gray conversion and the raster position of each pixel.
	sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_LINES(MAX_LINES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.fifo_full (fifo_full),
		.push      (push),
		.addr      (f_addr),
		.gray      (f_gray),
		.flags     (f_flags)
	);

	assign push_data = {f_addr, f_gray, f_flags};

	sem_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (fifo_full),
		.pop    (pop),
		.dout   (pop_data),
		.empty  (fifo_empty)
	);

	assign {b_addr, b_gray, b_flags} = pop_data;

	// Back end: line stores, window, gradient arithmetic and the result register.
	sem_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.addr       (b_addr),
		.gray       (b_gray),
		.flags      (b_flags),
		.pop        (pop),
		.res        (res)
	);

endmodule
